>>> sv/sumo_pkg.sv
`default_nettype none

package sumo_pkg;

    // Referee remote codes.
    localparam logic [2:0] CMD_NONE  = 3'd0;
    localparam logic [2:0] CMD_READY = 3'd1;
    localparam logic [2:0] CMD_RUN   = 3'd2;
    localparam logic [2:0] CMD_STOP  = 3'd3;
    localparam logic [2:0] CMD_PICK0 = 3'd4;
    localparam logic [2:0] CMD_PICK1 = 3'd5;
    localparam logic [2:0] CMD_PICK2 = 3'd6;

    // LED codes.
    localparam logic [1:0] LED_KEEP    = 2'd0;
    localparam logic [1:0] LED_GREEN   = 2'd1;
    localparam logic [1:0] LED_RED     = 2'd2;
    localparam logic [1:0] LED_MAGENTA = 2'd3;

    // Opening moves.
    localparam logic [1:0]  OPEN_SHORT  = 2'd0;
    localparam logic [1:0]  OPEN_ARC    = 2'd1;
    localparam logic [1:0]  OPEN_LONG   = 2'd2;
    localparam logic [15:0] LIM_SHORT   = 16'd500;
    localparam logic [15:0] LIM_ARC     = 16'd3000;
    localparam logic [15:0] LIM_LONG    = 16'd60000;

    localparam logic signed [10:0] SPD_ZERO = 11'sd0;
    localparam logic signed [10:0] SPD_200  = 11'sd200;
    localparam logic signed [10:0] SPD_400  = 11'sd400;
    localparam logic signed [10:0] SPD_600  = 11'sd600;
    localparam logic signed [10:0] SPD_1000 = 11'sd1000;
    localparam logic signed [10:0] SPD_N200 = -11'sd200;
    localparam logic signed [10:0] SPD_N700 = -11'sd700;
    localparam logic signed [10:0] SPD_N800 = -11'sd800;

    // Steering thresholds on the target offset.
    localparam logic signed [9:0] OFS_NEAR = 10'sd60;
    localparam logic signed [9:0] OFS_FAR  = 10'sd150;

    // Escape timing in ms.
    localparam logic [8:0] ESC_FIRST = 9'd200;
    localparam logic [8:0] ESC_HELD  = 9'd300;

    // Distance processing.
    localparam logic [12:0] DIST_MAX   = 13'd300;
    localparam logic [11:0] DIV6_MUL   = 12'd2731;
    localparam int          DIV6_SHIFT = 14;

    typedef struct packed {
        logic [2:0]  remote_code;
        logic        border_right;
        logic        border_left;
        logic        sample_valid;
        logic [12:0] dist_0;
        logic [12:0] dist_1;
        logic [12:0] dist_2;
        logic [12:0] dist_3;
        logic [31:0] now_ms;
    } t_item;

    typedef struct packed {
        logic              drive_valid;
        logic signed [10:0] motor_a_speed;
        logic signed [10:0] motor_b_speed;
        logic [1:0]        led_code;
    } t_result;

    typedef struct packed {
        logic signed [9:0] offset;
        logic              absent;
    } t_target;

endpackage

`default_nettype wire

>>> sv/sumo_target.sv
`default_nettype none

module sumo_target (
    input  wire logic [12:0]      i_dist_0,
    input  wire logic [12:0]      i_dist_1,
    input  wire logic [12:0]      i_dist_2,
    input  wire logic [12:0]      i_dist_3,
    output sumo_pkg::t_target     o_target
);

    logic [8:0]  w_c0, w_c1, w_c2, w_c3;
    logic [10:0] w_pos, w_neg;
    logic [22:0] w_pos_prod, w_neg_prod;
    logic [8:0]  w_p, w_q;

    // Readings beyond range count as no reading.
    assign w_c0 = (i_dist_0 > sumo_pkg::DIST_MAX) ? 9'd0 : i_dist_0[8:0];
    assign w_c1 = (i_dist_1 > sumo_pkg::DIST_MAX) ? 9'd0 : i_dist_1[8:0];
    assign w_c2 = (i_dist_2 > sumo_pkg::DIST_MAX) ? 9'd0 : i_dist_2[8:0];
    assign w_c3 = (i_dist_3 > sumo_pkg::DIST_MAX) ? 9'd0 : i_dist_3[8:0];

    // (25*a + 5*b) / 30 equals (5*a + b) / 6; the divide by six is a
    // reciprocal multiply that is exact for sums up to 1800.
    assign w_pos = 11'(w_c0) * 11'd5 + 11'(w_c1);
    assign w_neg = 11'(w_c3) * 11'd5 + 11'(w_c2);

    assign w_pos_prod = 23'(w_pos) * 23'(sumo_pkg::DIV6_MUL);
    assign w_neg_prod = 23'(w_neg) * 23'(sumo_pkg::DIV6_MUL);

    assign w_p = w_pos_prod[sumo_pkg::DIV6_SHIFT +: 9];
    assign w_q = w_neg_prod[sumo_pkg::DIV6_SHIFT +: 9];

    assign o_target.absent = (w_p == 9'd0) && (w_q == 9'd0);
    assign o_target.offset = $signed({1'b0, w_p}) - $signed({1'b0, w_q});

endmodule

`default_nettype wire

>>> sv/sumo_ctrl.sv
`default_nettype none

module sumo_ctrl #(
    parameter int TIME_BITS = 32
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_adv,
    input  wire sumo_pkg::t_item  i_item,
    output sumo_pkg::t_result     o_result
);

    logic [2:0]           r_last_cmd,      n_last_cmd;
    logic [1:0]           r_choice,        n_choice;
    logic                 r_open_started,  n_open_started;
    logic                 r_open_finished, n_open_finished;
    logic [TIME_BITS-1:0] r_open_start,    n_open_start;
    logic                 r_esc_active,    n_esc_active;
    logic [8:0]           r_esc_dur,       n_esc_dur;
    logic [TIME_BITS-1:0] r_phase_start,   n_phase_start;
    logic                 r_line_now,      n_line_now;
    logic                 r_line_before,   n_line_before;
    logic signed [9:0]    r_tgt_offset,    n_tgt_offset;
    logic                 r_tgt_absent,    n_tgt_absent;
    logic signed [10:0]   r_hold_a,        n_hold_a;
    logic signed [10:0]   r_hold_b,        n_hold_b;

    sumo_pkg::t_target    w_target;
    logic [63:0]          w_now_wide;
    logic [TIME_BITS-1:0] w_now;

    sumo_target u_target (
        .i_dist_0 (i_item.dist_0),
        .i_dist_1 (i_item.dist_1),
        .i_dist_2 (i_item.dist_2),
        .i_dist_3 (i_item.dist_3),
        .o_target (w_target)
    );

    assign w_now_wide = {32'd0, i_item.now_ms};
    assign w_now      = w_now_wide[TIME_BITS-1:0];

    always_comb begin
        logic [2:0]           code;
        logic [TIME_BITS-1:0] open_el;
        logic [TIME_BITS-1:0] esc_el;
        logic [15:0]          open_lim;
        logic signed [10:0]   open_a;
        logic signed [10:0]   open_b;
        logic                 open_ok;
        logic                 esc;
        logic [8:0]           dur;

        n_last_cmd      = r_last_cmd;
        n_choice        = r_choice;
        n_open_started  = r_open_started;
        n_open_finished = r_open_finished;
        n_open_start    = r_open_start;
        n_esc_active    = r_esc_active;
        n_esc_dur       = r_esc_dur;
        n_phase_start   = r_phase_start;
        n_line_now      = r_line_now;
        n_line_before   = r_line_before;
        n_tgt_offset    = r_tgt_offset;
        n_tgt_absent    = r_tgt_absent;
        n_hold_a        = r_hold_a;
        n_hold_b        = r_hold_b;
        o_result        = '0;
        open_el         = '0;
        esc_el          = '0;
        open_lim        = '0;
        open_a          = sumo_pkg::SPD_ZERO;
        open_b          = sumo_pkg::SPD_ZERO;
        open_ok         = 1'b0;
        esc             = r_esc_active;
        dur             = r_esc_dur;

        code = i_item.remote_code;
        // An idle or ready code keeps a running robot running.
        if (r_last_cmd == sumo_pkg::CMD_RUN &&
            (code == sumo_pkg::CMD_NONE || code == sumo_pkg::CMD_READY)) begin
            code = sumo_pkg::CMD_RUN;
        end

        unique case (code)
            sumo_pkg::CMD_READY: begin
                n_last_cmd        = sumo_pkg::CMD_READY;
                o_result.led_code = sumo_pkg::LED_GREEN;
                n_phase_start     = w_now;
            end
            sumo_pkg::CMD_RUN: begin
                // Opening move.
                if (!r_open_started) begin
                    n_open_start = w_now;
                end
                n_open_started = 1'b1;
                open_el = w_now - n_open_start;
                unique case (r_choice)
                    sumo_pkg::OPEN_SHORT: begin
                        open_ok  = 1'b1;
                        open_lim = sumo_pkg::LIM_SHORT;
                        open_a   = sumo_pkg::SPD_400;
                        open_b   = sumo_pkg::SPD_400;
                    end
                    sumo_pkg::OPEN_ARC: begin
                        open_ok  = 1'b1;
                        open_lim = sumo_pkg::LIM_ARC;
                        open_a   = sumo_pkg::SPD_1000;
                        open_b   = sumo_pkg::SPD_600;
                    end
                    sumo_pkg::OPEN_LONG: begin
                        open_ok  = 1'b1;
                        open_lim = sumo_pkg::LIM_LONG;
                        open_a   = sumo_pkg::SPD_1000;
                        open_b   = sumo_pkg::SPD_600;
                    end
                    default: begin
                        open_ok = 1'b0;
                    end
                endcase
                if (!r_open_finished && open_ok) begin
                    if (open_el <= TIME_BITS'(open_lim)) begin
                        n_hold_a = open_a;
                        n_hold_b = open_b;
                    end else begin
                        n_open_finished = 1'b1;
                    end
                end

                // Target tracking once the opening is over.
                if (n_open_finished) begin
                    if (i_item.sample_valid) begin
                        n_tgt_absent = w_target.absent;
                        n_tgt_offset = w_target.absent ? 10'sd0 : w_target.offset;
                    end
                    if (!r_esc_active) begin
                        priority if (n_tgt_absent) begin
                            n_hold_a = sumo_pkg::SPD_ZERO;
                            n_hold_b = sumo_pkg::SPD_ZERO;
                        end else if (n_tgt_offset > sumo_pkg::OFS_NEAR &&
                                     n_tgt_offset < sumo_pkg::OFS_FAR) begin
                            n_hold_a = sumo_pkg::SPD_600;
                            n_hold_b = sumo_pkg::SPD_200;
                        end else if (n_tgt_offset > -sumo_pkg::OFS_FAR &&
                                     n_tgt_offset < -sumo_pkg::OFS_NEAR) begin
                            n_hold_a = sumo_pkg::SPD_200;
                            n_hold_b = sumo_pkg::SPD_600;
                        end else if (n_tgt_offset < -sumo_pkg::OFS_FAR) begin
                            n_hold_a = sumo_pkg::SPD_200;
                            n_hold_b = sumo_pkg::SPD_400;
                        end else if (n_tgt_offset > sumo_pkg::OFS_FAR) begin
                            n_hold_a = sumo_pkg::SPD_400;
                            n_hold_b = sumo_pkg::SPD_200;
                        end else begin
                            n_hold_a = sumo_pkg::SPD_ZERO;
                            n_hold_b = sumo_pkg::SPD_ZERO;
                        end
                    end
                end

                // Border escape. The phase timer restarts one pass after
                // the border flag changes.
                if (r_line_now != r_line_before) begin
                    n_phase_start = w_now;
                end
                n_line_before = r_line_now;
                if (i_item.border_right || i_item.border_left) begin
                    dur        = sumo_pkg::ESC_FIRST;
                    n_line_now = 1'b1;
                    esc        = 1'b1;
                end else begin
                    n_line_now = 1'b0;
                end
                esc_el = w_now - n_phase_start;
                if (esc && esc_el < TIME_BITS'(dur)) begin
                    priority if (i_item.border_right && i_item.border_left) begin
                        dur      = sumo_pkg::ESC_HELD;
                        n_hold_a = sumo_pkg::SPD_N700;
                        n_hold_b = sumo_pkg::SPD_N700;
                    end else if (i_item.border_right) begin
                        dur      = sumo_pkg::ESC_HELD;
                        n_hold_a = sumo_pkg::SPD_N200;
                        n_hold_b = sumo_pkg::SPD_N800;
                    end else if (i_item.border_left) begin
                        dur      = sumo_pkg::ESC_HELD;
                        n_hold_a = sumo_pkg::SPD_N800;
                        n_hold_b = sumo_pkg::SPD_N200;
                    end else begin
                        n_hold_a = sumo_pkg::SPD_N700;
                        n_hold_b = sumo_pkg::SPD_N700;
                    end
                end else begin
                    dur = 9'd0;
                    esc = 1'b0;
                end
                n_esc_dur    = dur;
                n_esc_active = esc;

                o_result.drive_valid   = 1'b1;
                o_result.motor_a_speed = n_hold_a;
                o_result.motor_b_speed = n_hold_b;
                n_last_cmd             = sumo_pkg::CMD_RUN;
            end
            sumo_pkg::CMD_STOP: begin
                o_result.drive_valid = 1'b1;
                o_result.led_code    = sumo_pkg::LED_RED;
                n_esc_dur            = 9'd0;
                n_esc_active         = 1'b0;
                n_last_cmd           = sumo_pkg::CMD_STOP;
                n_open_started       = 1'b0;
                n_open_finished      = 1'b0;
            end
            sumo_pkg::CMD_PICK0, sumo_pkg::CMD_PICK1, sumo_pkg::CMD_PICK2: begin
                n_choice   = 2'(code - sumo_pkg::CMD_PICK0);
                n_last_cmd = code;
                if (code != sumo_pkg::CMD_PICK2) begin
                    o_result.led_code = sumo_pkg::LED_MAGENTA;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_cmd      <= sumo_pkg::CMD_NONE;
            r_choice        <= sumo_pkg::OPEN_SHORT;
            r_open_started  <= 1'b0;
            r_open_finished <= 1'b0;
            r_open_start    <= '0;
            r_esc_active    <= 1'b0;
            r_esc_dur       <= 9'd0;
            r_phase_start   <= '0;
            r_line_now      <= 1'b0;
            r_line_before   <= 1'b0;
            r_tgt_offset    <= 10'sd0;
            r_tgt_absent    <= 1'b0;
            r_hold_a        <= sumo_pkg::SPD_ZERO;
            r_hold_b        <= sumo_pkg::SPD_ZERO;
        end else if (i_adv) begin
            r_last_cmd      <= n_last_cmd;
            r_choice        <= n_choice;
            r_open_started  <= n_open_started;
            r_open_finished <= n_open_finished;
            r_open_start    <= n_open_start;
            r_esc_active    <= n_esc_active;
            r_esc_dur       <= n_esc_dur;
            r_phase_start   <= n_phase_start;
            r_line_now      <= n_line_now;
            r_line_before   <= n_line_before;
            r_tgt_offset    <= n_tgt_offset;
            r_tgt_absent    <= n_tgt_absent;
            r_hold_a        <= n_hold_a;
            r_hold_b        <= n_hold_b;
        end
    end

endmodule

`default_nettype wire

>>> sv/sumo_robot_behavior_controller.sv
// Sumo robot behavior controller.
// One transfer on the slave stream is one control pass: referee remote code,
// two ring-border flags, an optional set of four distance readings (flagged
// by tuser) and the time in ms. Each pass yields exactly one transfer on the
// master stream with the motor speeds, the LED code and, in tuser, whether
// the speeds are to be applied.
// A result passes through the input register and then the result register
// before it is offered on the master side, and it transfers when the master
// side is not stalled (one input register, one result register).
// Throughput: one pass per cycle when not stalled; all per-pass work is one
// combinational step between the input and result registers, including the
// two time-difference compares and the divide-by-six of the target offset.
// A new input is taken while a result waits, as long as the input register
// can advance; when the receiver holds tready low the result register and
// then the input register fill, and s_axis tready drops until a transfer
// happens on the master side. Nothing is lost or repeated.
// Reset (synchronous, active low) empties both registers and returns the
// behavior state to idle with no command, with opening move zero selected.
`default_nettype none

module sumo_robot_behavior_controller #(
    parameter int TIME_BITS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output      logic        o_s_axis_tready,
    // remote_code[2:0], border_right[3], border_left[4], dist_0[17:5],
    // dist_1[30:18], dist_2[43:31], dist_3[56:44], now_ms[88:57], zero fill
    input  wire logic [95:0] i_s_axis_tdata,
    // sample_valid[0]
    input  wire logic        i_s_axis_tuser,
    output      logic        o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // motor_a_speed[10:0], motor_b_speed[21:11], led_code[23:22]
    output      logic [23:0] o_m_axis_tdata,
    // drive_valid[0]
    output      logic        o_m_axis_tuser
);

    logic              r_in_valid;
    sumo_pkg::t_item   r_in_item;
    logic              r_out_valid;
    sumo_pkg::t_result r_out_res;
    sumo_pkg::t_result w_res;
    sumo_pkg::t_item   w_item;
    logic              w_adv;

    assign w_item.remote_code  = i_s_axis_tdata[2:0];
    assign w_item.border_right = i_s_axis_tdata[3];
    assign w_item.border_left  = i_s_axis_tdata[4];
    assign w_item.sample_valid = i_s_axis_tuser;
    assign w_item.dist_0       = i_s_axis_tdata[17:5];
    assign w_item.dist_1       = i_s_axis_tdata[30:18];
    assign w_item.dist_2       = i_s_axis_tdata[43:31];
    assign w_item.dist_3       = i_s_axis_tdata[56:44];
    assign w_item.now_ms       = i_s_axis_tdata[88:57];

    // The held item moves into the result register when that is free or
    // being emptied in the same cycle.
    assign w_adv           = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_adv;

    sumo_ctrl #(
        .TIME_BITS (TIME_BITS)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (w_adv),
        .i_item   (r_in_item),
        .o_result (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_item <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_res <= w_res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_res.led_code, r_out_res.motor_b_speed,
                              r_out_res.motor_a_speed};
    assign o_m_axis_tuser  = r_out_res.drive_valid;

endmodule

`default_nettype wire

>>> sv/sumo_chk.sv
`default_nettype none

module sumo_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_m_axis_tvalid,
    input wire logic        i_m_axis_tready,
    input wire logic [23:0] o_m_axis_tdata,
    input wire logic        o_m_axis_tuser
);

    // A stalled result holds until its transfer.
    a_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("master stream result changed while stalled");

    // Without drive both speed fields are zero.
    a_idle_speeds : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser |-> o_m_axis_tdata[21:0] == 22'd0)
        else $error("speeds nonzero while drive is off");

    // Red LED comes only from a stop pass, which drives zero speeds.
    a_stop : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[23:22] == sumo_pkg::LED_RED |->
            o_m_axis_tuser && o_m_axis_tdata[21:0] == 22'd0)
        else $error("stop result malformed");

    // Green and magenta come from passes that never drive.
    a_setup_led : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tdata[23:22] == sumo_pkg::LED_GREEN ||
                            o_m_axis_tdata[23:22] == sumo_pkg::LED_MAGENTA) |->
            !o_m_axis_tuser)
        else $error("drive set on a setup pass");

    // Reset empties the result register.
    a_reset : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

bind sumo_robot_behavior_controller sumo_chk u_sumo_chk (.*);

`default_nettype wire

>>> test/tb.sv
module tb;

    // Remote code with no meaning; the block must ignore it.
    localparam logic [2:0] CMD_UNUSED  = 3'd7;
    localparam int         ITEMS       = 1950;
    localparam int         STALL_LEN   = 300;
    localparam int         MAX_REPORTS = 10;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic [95:0] i_s_axis_tdata  = '0;
    logic        i_s_axis_tuser  = 1'b0;
    logic        i_m_axis_tready = 1'b0;
    wire         o_s_axis_tready;
    wire         o_m_axis_tvalid;
    wire  [23:0] o_m_axis_tdata;
    wire         o_m_axis_tuser;

    // Behavior state of the controller as predicted by the testbench.
    logic [2:0]         mode_cmd          = sumo_pkg::CMD_NONE;
    logic [1:0]         open_sel          = sumo_pkg::OPEN_SHORT;
    logic               open_armed        = 1'b0;
    logic               open_done         = 1'b0;
    logic [31:0]        open_t0           = '0;
    logic               esc_on            = 1'b0;
    logic [8:0]         esc_len           = '0;
    logic [31:0]        line_t0           = '0;
    logic               border_seen       = 1'b0;
    logic               border_seen_last  = 1'b0;
    logic signed [9:0]  aim_ofs           = '0;
    logic               aim_none          = 1'b0;
    logic signed [10:0] hold_a            = '0;
    logic signed [10:0] hold_b            = '0;

    sumo_pkg::t_result expected_drive[$];
    int          mismatches  = 0;
    int          sent        = 0;
    int          held_cycles = 0;
    logic        quiet       = 1'b0;
    logic        stall_go    = 1'b0;
    logic [31:0] clock_ms    = '0;

    sumo_robot_behavior_controller u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [12:0] clip_mm(input logic [12:0] d);
        return (d > sumo_pkg::DIST_MAX) ? 13'd0 : d;
    endfunction

    // One control pass: updates the predicted state and returns the drive result.
    function automatic sumo_pkg::t_result predict_pass(input sumo_pkg::t_item it);
        logic [2:0]         cmd;
        logic [31:0]        dt;
        logic [31:0]        lim;
        logic signed [10:0] sa;
        logic signed [10:0] sb;
        logic               move_ok;
        int                 p;
        int                 n;
        sumo_pkg::t_result  r;
        r   = '0;
        lim = '0;
        sa  = sumo_pkg::SPD_ZERO;
        sb  = sumo_pkg::SPD_ZERO;
        cmd = it.remote_code;
        // An empty or ready code keeps the robot running.
        if (mode_cmd == sumo_pkg::CMD_RUN && cmd <= sumo_pkg::CMD_READY)
            cmd = sumo_pkg::CMD_RUN;
        case (cmd)
            sumo_pkg::CMD_READY: begin
                mode_cmd   = sumo_pkg::CMD_READY;
                r.led_code = sumo_pkg::LED_GREEN;
                line_t0    = it.now_ms;
            end
            sumo_pkg::CMD_RUN: begin
                if (!open_armed) begin
                    open_t0    = it.now_ms;
                    open_armed = 1'b1;
                end
                if (!open_done) begin
                    move_ok = 1'b1;
                    case (open_sel)
                        sumo_pkg::OPEN_SHORT: begin
                            lim = 32'(sumo_pkg::LIM_SHORT);
                            sa  = sumo_pkg::SPD_400;
                            sb  = sumo_pkg::SPD_400;
                        end
                        sumo_pkg::OPEN_ARC: begin
                            lim = 32'(sumo_pkg::LIM_ARC);
                            sa  = sumo_pkg::SPD_1000;
                            sb  = sumo_pkg::SPD_600;
                        end
                        sumo_pkg::OPEN_LONG: begin
                            lim = 32'(sumo_pkg::LIM_LONG);
                            sa  = sumo_pkg::SPD_1000;
                            sb  = sumo_pkg::SPD_600;
                        end
                        default: move_ok = 1'b0;
                    endcase
                    dt = it.now_ms - open_t0;
                    if (move_ok && dt <= lim) begin
                        hold_a = sa;
                        hold_b = sb;
                    end else if (move_ok) begin
                        open_done = 1'b1;
                    end
                end
                if (open_done) begin
                    if (it.sample_valid) begin
                        p = (25 * int'(clip_mm(it.dist_0)) +
                             5 * int'(clip_mm(it.dist_1))) / 30;
                        n = (-5 * int'(clip_mm(it.dist_2)) -
                             25 * int'(clip_mm(it.dist_3))) / 30;
                        aim_none = (p == 0 && n == 0);
                        aim_ofs  = aim_none ? 10'sd0 : 10'(p + n);
                    end
                    if (!esc_on) begin
                        sa = sumo_pkg::SPD_ZERO;
                        sb = sumo_pkg::SPD_ZERO;
                        if (aim_none) begin
                            sa = sumo_pkg::SPD_ZERO;
                        end else if (aim_ofs > sumo_pkg::OFS_NEAR &&
                                     aim_ofs < sumo_pkg::OFS_FAR) begin
                            sa = sumo_pkg::SPD_600;
                            sb = sumo_pkg::SPD_200;
                        end else if (aim_ofs > -sumo_pkg::OFS_FAR &&
                                     aim_ofs < -sumo_pkg::OFS_NEAR) begin
                            sa = sumo_pkg::SPD_200;
                            sb = sumo_pkg::SPD_600;
                        end else if (aim_ofs < -sumo_pkg::OFS_FAR) begin
                            sa = sumo_pkg::SPD_200;
                            sb = sumo_pkg::SPD_400;
                        end else if (aim_ofs > sumo_pkg::OFS_FAR) begin
                            sa = sumo_pkg::SPD_400;
                            sb = sumo_pkg::SPD_200;
                        end
                        hold_a = sa;
                        hold_b = sb;
                    end
                end
                // The escape timer restarts one pass after the border flag changes.
                if (border_seen != border_seen_last)
                    line_t0 = it.now_ms;
                border_seen_last = border_seen;
                if (it.border_right || it.border_left) begin
                    esc_len     = sumo_pkg::ESC_FIRST;
                    border_seen = 1'b1;
                    esc_on      = 1'b1;
                end else begin
                    border_seen = 1'b0;
                end
                dt = it.now_ms - line_t0;
                if (esc_on && dt < 32'(esc_len)) begin
                    if (it.border_right && it.border_left) begin
                        esc_len = sumo_pkg::ESC_HELD;
                        hold_a  = sumo_pkg::SPD_N700;
                        hold_b  = sumo_pkg::SPD_N700;
                    end else if (it.border_right) begin
                        esc_len = sumo_pkg::ESC_HELD;
                        hold_a  = sumo_pkg::SPD_N200;
                        hold_b  = sumo_pkg::SPD_N800;
                    end else if (it.border_left) begin
                        esc_len = sumo_pkg::ESC_HELD;
                        hold_a  = sumo_pkg::SPD_N800;
                        hold_b  = sumo_pkg::SPD_N200;
                    end else begin
                        hold_a = sumo_pkg::SPD_N700;
                        hold_b = sumo_pkg::SPD_N700;
                    end
                end else begin
                    esc_len = '0;
                    esc_on  = 1'b0;
                end
                r.drive_valid   = 1'b1;
                r.motor_a_speed = hold_a;
                r.motor_b_speed = hold_b;
                mode_cmd        = sumo_pkg::CMD_RUN;
            end
            sumo_pkg::CMD_STOP: begin
                r.drive_valid = 1'b1;
                r.led_code    = sumo_pkg::LED_RED;
                esc_len       = '0;
                esc_on        = 1'b0;
                mode_cmd      = sumo_pkg::CMD_STOP;
                open_armed    = 1'b0;
                open_done     = 1'b0;
            end
            sumo_pkg::CMD_PICK0, sumo_pkg::CMD_PICK1, sumo_pkg::CMD_PICK2: begin
                open_sel = 2'(cmd - sumo_pkg::CMD_PICK0);
                mode_cmd = cmd;
                if (cmd != sumo_pkg::CMD_PICK2)
                    r.led_code = sumo_pkg::LED_MAGENTA;
            end
            default: ;
        endcase
        return r;
    endfunction

    // Offers one pass and holds it until the transfer, then records its result.
    task automatic send_pass(input logic [2:0] code, input logic br, input logic bl,
                             input logic sv, input logic [12:0] d0, input logic [12:0] d1,
                             input logic [12:0] d2, input logic [12:0] d3,
                             input logic [31:0] now);
        sumo_pkg::t_item   it;
        sumo_pkg::t_result r;
        it.remote_code  = code;
        it.border_right = br;
        it.border_left  = bl;
        it.sample_valid = sv;
        it.dist_0       = d0;
        it.dist_1       = d1;
        it.dist_2       = d2;
        it.dist_3       = d3;
        it.now_ms       = now;
        if (!quiet && $urandom_range(99) < 21) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(2, 1)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {7'd0, now, d3, d2, d1, d0, bl, br, code};
        i_s_axis_tuser  <= sv;
        do @(posedge i_clk); while (o_s_axis_tready !== 1'b1);
        r = predict_pass(it);
        expected_drive.push_back(r);
        sent++;
    endtask

    // Receiver: random stalls, a quiet stretch, and one long hold-off.
    always @(posedge i_clk) begin
        if (stall_go && held_cycles < STALL_LEN) begin
            i_m_axis_tready <= 1'b0;
            held_cycles     <= held_cycles + 1;
        end else if (quiet) begin
            i_m_axis_tready <= 1'b1;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= 21);
        end
    end

    always @(posedge i_clk) begin : check_drive
        sumo_pkg::t_result want;
        sumo_pkg::t_result got;
        if (i_rst_n && o_m_axis_tvalid === 1'b1 && i_m_axis_tready) begin
            got.drive_valid   = o_m_axis_tuser;
            got.motor_a_speed = o_m_axis_tdata[10:0];
            got.motor_b_speed = o_m_axis_tdata[21:11];
            got.led_code      = o_m_axis_tdata[23:22];
            if (expected_drive.size() == 0) begin
                if (mismatches < MAX_REPORTS)
                    $display("%0t: result transfer with no pass pending", $time);
                mismatches++;
            end else begin
                want = expected_drive.pop_front();
                if (got.drive_valid !== want.drive_valid ||
                    got.motor_a_speed !== want.motor_a_speed ||
                    got.motor_b_speed !== want.motor_b_speed ||
                    got.led_code !== want.led_code) begin
                    if (mismatches < MAX_REPORTS)
                        $display("%0t: mismatch exp %0b %0d %0d %0d got %0b %0d %0d %0d",
                                 $time, want.drive_valid, want.motor_a_speed,
                                 want.motor_b_speed, want.led_code, got.drive_valid,
                                 got.motor_a_speed, got.motor_b_speed, got.led_code);
                    mismatches++;
                end
            end
        end
    end

    task test_commands;
        send_pass(sumo_pkg::CMD_NONE, 1'b0, 1'b0, 1'b0, 13'd0, 13'd0, 13'd0, 13'd0,
                  32'd0);
        send_pass(CMD_UNUSED, 1'b1, 1'b1, 1'b1, 13'h1FFF, 13'h1FFF, 13'h1FFF, 13'h1FFF,
                  32'hFFFF_FFFF);
        send_pass(sumo_pkg::CMD_PICK0, 1'b0, 1'b0, 1'b0, 13'd0, 13'd0, 13'd0, 13'd0,
                  32'd10);
        send_pass(sumo_pkg::CMD_READY, 1'b0, 1'b0, 1'b0, 13'd0, 13'd0, 13'd0, 13'd0,
                  32'd20);
    endtask

    task test_opening_moves;
        logic [31:0] t;
        // Short move: the 500 ms bound is inclusive, readings are ignored meanwhile.
        send_pass(sumo_pkg::CMD_RUN, 1'b0, 1'b0, 1'b1, 13'd300, 13'd0, 13'd0, 13'd0,
                  32'd100);
        send_pass(sumo_pkg::CMD_NONE, 1'b0, 1'b0, 1'b0, 13'd0, 13'd0, 13'd0, 13'd0,
                  32'd600);
        send_pass(sumo_pkg::CMD_READY, 1'b0, 1'b0, 1'b1, 13'd300, 13'd301, 13'h1FFF,
                  13'd0, 32'd601);
        send_pass(sumo_pkg::CMD_STOP, 1'b0, 1'b0, 1'b0, 13'd0, 13'd0, 13'd0, 13'd0,
                  32'd610);
        send_pass(sumo_pkg::CMD_PICK2, 1'b0, 1'b0, 1'b0, 13'd0, 13'd0, 13'd0, 13'd0,
                  32'd620);
        // Long move started just before the time counter wraps.
        t = 32'hFFFF_FFF0;
        send_pass(sumo_pkg::CMD_RUN, 1'b0, 1'b0, 1'b0, 13'd0, 13'd0, 13'd0, 13'd0, t);
        send_pass(sumo_pkg::CMD_RUN, 1'b0, 1'b0, 1'b0, 13'd0, 13'd0, 13'd0, 13'd0,
                  t + 32'd60000);
        send_pass(sumo_pkg::CMD_RUN, 1'b0, 1'b0, 1'b0, 13'd0, 13'd0, 13'd0, 13'd0,
                  t + 32'd60001);
        send_pass(sumo_pkg::CMD_STOP, 1'b0, 1'b0, 1'b0, 13'd0, 13'd0, 13'd0, 13'd0,
                  t + 32'd60010);
        send_pass(sumo_pkg::CMD_PICK1, 1'b0, 1'b0, 1'b0, 13'd0, 13'd0, 13'd0, 13'd0,
                  t + 32'd60020);
        t = t + 32'd60030;
        send_pass(sumo_pkg::CMD_RUN, 1'b0, 1'b0, 1'b0, 13'd0, 13'd0, 13'd0, 13'd0, t);
        send_pass(sumo_pkg::CMD_NONE, 1'b0, 1'b0, 1'b0, 13'd0, 13'd0, 13'd0, 13'd0,
                  t + 32'd3000);
        send_pass(sumo_pkg::CMD_RUN, 1'b0, 1'b0, 1'b0, 13'd0, 13'd0, 13'd0, 13'd0,
                  t + 32'd3001);
        clock_ms = t + 32'd3001;
    endtask

    task test_steering;
        logic [12:0] probe [8][4];
        int          k;
        // Offsets of exactly 150, -150, 60, 61, -61, -300, 250, then readings
        // that are nonzero yet give no target.
        probe = '{'{13'd180, 13'd0, 13'd0, 13'd0}, '{13'd0, 13'd0, 13'd0, 13'd180},
                  '{13'd73, 13'd0, 13'd0, 13'd0}, '{13'd74, 13'd0, 13'd0, 13'd0},
                  '{13'd0, 13'd0, 13'd0, 13'd74}, '{13'd0, 13'd0, 13'd300, 13'd300},
                  '{13'd300, 13'd301, 13'h1FFF, 13'd0}, '{13'd0, 13'd5, 13'd0, 13'd0}};
        for (k = 0; k < 8; k++) begin
            clock_ms += 10;
            send_pass(sumo_pkg::CMD_RUN, 1'b0, 1'b0, 1'b1, probe[k][0], probe[k][1],
                      probe[k][2], probe[k][3], clock_ms);
        end
        // Without a new sample the last target is kept.
        clock_ms += 10;
        send_pass(sumo_pkg::CMD_RUN, 1'b0, 1'b0, 1'b0, 13'd0, 13'd0, 13'd0, 13'd180,
                  clock_ms);
    endtask

    task test_border_escape;
        logic [31:0] t;
        t = clock_ms;
        send_pass(sumo_pkg::CMD_RUN, 1'b1, 1'b0, 1'b1, 13'd0, 13'd0, 13'd0, 13'd180,
                  t + 32'd10);
        send_pass(sumo_pkg::CMD_RUN, 1'b1, 1'b0, 1'b0, 13'd0, 13'd0, 13'd0, 13'd0,
                  t + 32'd20);
        send_pass(sumo_pkg::CMD_RUN, 1'b1, 1'b1, 1'b0, 13'd0, 13'd0, 13'd0, 13'd0,
                  t + 32'd120);
        send_pass(sumo_pkg::CMD_NONE, 1'b0, 1'b1, 1'b0, 13'd0, 13'd0, 13'd0, 13'd0,
                  t + 32'd219);
        send_pass(sumo_pkg::CMD_RUN, 1'b0, 1'b0, 1'b0, 13'd0, 13'd0, 13'd0, 13'd0,
                  t + 32'd290);
        send_pass(sumo_pkg::CMD_READY, 1'b0, 1'b0, 1'b0, 13'd0, 13'd0, 13'd0, 13'd0,
                  t + 32'd300);
        send_pass(sumo_pkg::CMD_RUN, 1'b0, 1'b0, 1'b0, 13'd0, 13'd0, 13'd0, 13'd0,
                  t + 32'd600);
        send_pass(sumo_pkg::CMD_RUN, 1'b0, 1'b0, 1'b0, 13'd0, 13'd0, 13'd0, 13'd0,
                  t + 32'd610);
        clock_ms = t + 32'd610;
    endtask

    // One match: referee sequence, then a run of control passes with random content.
    task automatic run_bout(input int n_run);
        int          k;
        int          j;
        int          r;
        int          border_left;
        logic [2:0]  code;
        logic [1:0]  sides;
        logic [12:0] d [4];
        logic        blank;
        if ($urandom_range(9) < 3)
            clock_ms = $urandom();
        if ($urandom_range(1) == 0)
            send_pass(sumo_pkg::CMD_STOP, 1'($urandom), 1'($urandom), 1'($urandom),
                      13'($urandom), 13'($urandom), 13'($urandom), 13'($urandom),
                      clock_ms);
        r    = $urandom_range(9);
        code = (r < 5) ? sumo_pkg::CMD_PICK0 :
               ((r < 8) ? sumo_pkg::CMD_PICK1 : sumo_pkg::CMD_PICK2);
        clock_ms += $urandom_range(50);
        send_pass(code, 1'($urandom), 1'($urandom), 1'($urandom), 13'($urandom),
                  13'($urandom), 13'($urandom), 13'($urandom), clock_ms);
        if ($urandom_range(4) != 0) begin
            clock_ms += $urandom_range(50);
            send_pass(sumo_pkg::CMD_READY, 1'($urandom), 1'($urandom), 1'($urandom),
                      13'($urandom), 13'($urandom), 13'($urandom), 13'($urandom),
                      clock_ms);
        end
        border_left = 0;
        for (k = 0; k < n_run; k++) begin
            r = $urandom_range(99);
            if (r < 55)
                clock_ms += $urandom_range(30);
            else if (r < 85)
                clock_ms += $urandom_range(250, 31);
            else if (r < 95)
                clock_ms += $urandom_range(3500, 251);
            else
                clock_ms += $urandom_range(70000);
            blank = ($urandom_range(9) == 0);
            for (j = 0; j < 4; j++) begin
                r = $urandom_range(99);
                if (blank || r < 20)
                    d[j] = '0;
                else if (r < 75)
                    d[j] = 13'($urandom_range(300));
                else if (r < 88)
                    d[j] = 13'($urandom_range(400, 301));
                else
                    d[j] = 13'($urandom);
            end
            if ($urandom_range(99) < 5) begin
                if ($urandom_range(2) == 0)
                    clock_ms = $urandom();
                send_pass(3'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                          13'($urandom), 13'($urandom), 13'($urandom), 13'($urandom),
                          clock_ms);
            end else begin
                r    = $urandom_range(99);
                code = (r < 60) ? sumo_pkg::CMD_RUN :
                       ((r < 85) ? sumo_pkg::CMD_NONE : sumo_pkg::CMD_READY);
                if (border_left == 0 && $urandom_range(99) < 8)
                    border_left = $urandom_range(6, 1);
                sides = '0;
                if (border_left > 0) begin
                    sides = 2'($urandom_range(3, 1));
                    border_left--;
                end
                send_pass(code, sides[0], sides[1], $urandom_range(3) != 0, d[0], d[1],
                          d[2], d[3], clock_ms);
            end
        end
    endtask

    // The receiver holds off while passes keep coming, so the block stalls its input.
    task test_backpressure;
        stall_go <= 1'b1;
        run_bout(40);
        stall_go <= 1'b0;
    endtask

    task test_random_bouts;
        while (sent < ITEMS) begin
            quiet <= (sent >= 800 && sent < 1100);
            run_bout($urandom_range(60, 10));
        end
        quiet <= 1'b0;
    endtask

    initial begin
        int waited;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_commands();
        test_opening_moves();
        test_steering();
        test_border_escape();
        test_backpressure();
        test_random_bouts();
        i_s_axis_tvalid <= 1'b0;
        waited = 0;
        while (expected_drive.size() != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (10) @(posedge i_clk);
        if (expected_drive.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, expected_drive.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

    initial begin
        #3000000;
        $display("tb: errors");
        $finish;
    end

endmodule

>>> files.f
sv/sumo_pkg.sv
sv/sumo_target.sv
sv/sumo_ctrl.sv
sv/sumo_robot_behavior_controller.sv
sv/sumo_chk.sv
test/tb.sv
